// ===== design/keyframe_animation_sequencer_defines.svh =====
// Assertion macros for the keyframe animation sequencer.
// Included by the top level; no other dependencies.
`ifndef KEYFRAME_ANIMATION_SEQUENCER_DEFINES_SVH
`define KEYFRAME_ANIMATION_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define KAS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define KAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KAS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define KAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/kas_pkg.sv =====
// Shared types and constants for the keyframe animation sequencer.
// No dependencies.
`default_nettype none

package kas_pkg;

   localparam int NUM_ANIMS_DEF = 32;
   localparam int ANIM_IDX_W    = 7;
   localparam int REQ_W         = 8;
   localparam int FIELD_W       = 10;
   localparam int FRAME_W       = 11;
   localparam int TIME_W        = 31;
   localparam int DUE_W         = 32;
   localparam int FT_W          = DUE_W + 1;
   localparam int DIFF_W        = FT_W + 1;
   localparam int DIV_W         = 32;
   localparam int LEAD_LIMIT    = 200;
   localparam int LEAD_W        = 8;
   localparam int FRAC_W        = 16;
   localparam int ONE_Q16       = 65536;
   localparam int LERP_W        = 17;
   localparam int MOD_SUM_W     = 12;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [FIELD_W-1:0] start_delay;
      logic [FIELD_W-1:0] frame_period;
      logic [FIELD_W-1:0] loop_frames;
      logic [FIELD_W-1:0] num_frames;
      logic [FIELD_W-1:0] first_frame;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             busy;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_DIFF,
      ST_QUO_GO,
      ST_QUO_WAIT,
      ST_MOD_GO,
      ST_MOD_WAIT,
      ST_CLAMP,
      ST_LIMIT,
      ST_LERP_GO,
      ST_LERP_WAIT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== design/kas_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on kas_pkg.
`default_nettype none

module kas_div (
   input  wire                  clock,
   input  wire                  reset,
   input  kas_pkg::div_req_type div_req,
   output kas_pkg::div_rsp_type div_rsp
);
   import kas_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;

   logic [DIV_W:0]   partial;
   logic [DIV_W:0]   trial;
   logic             fits;

   // quo_ff shifts the dividend out at the top while quotient bits enter below
   assign partial = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = partial - {1'b0, dvs_ff};
   assign fits    = partial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIV_W);
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[DIV_W-1:0] : partial[DIV_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.busy      = busy_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/kas_table.sv =====
// Animation table memory: one write port, one registered read port.
// Depends on kas_pkg.
`default_nettype none

module kas_table #(
   parameter int NUM_ANIMS = kas_pkg::NUM_ANIMS_DEF,
   parameter int ADDR_W    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1
) (
   input  wire                 clock,
   input  wire                 wr_en,
   input  wire  [ADDR_W-1:0]   wr_addr,
   input  kas_pkg::entry_type  wr_data,
   input  wire                 rd_en,
   input  wire  [ADDR_W-1:0]   rd_addr,
   output kas_pkg::entry_type  rd_data
);
   import kas_pkg::*;

   entry_type entry_mem [NUM_ANIMS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/keyframe_animation_sequencer.sv =====
// Keyframe animation sequencer: top level, sequencer FSM and datapath.
// Depends on kas_pkg, kas_table, kas_div and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   req_    | in        | req_valid/req_stall  | opcode, anim_request, now_time, load fields
//   rsp_    | out       | rsp_valid/rsp_stall  | old_frame, cur_frame, back_lerp, bad_index
//
// A load goes straight to the emit state. A tick divides for the back lerp ratio unless the
// blend interval is empty, adds a frame offset division when a frame is due and a loop modulo
// division when it also wraps into the loop tail; all of these share one divider.
// req_stall is high from the accepting edge until the result is in the output register;
// the output register is loaded again while a previous result waits only if it is taken.
// Synchronous active-high reset clears the frame state; table entries stay as they are.
`default_nettype none
`include "keyframe_animation_sequencer_defines.svh"

module keyframe_animation_sequencer #(
   parameter int NUM_ANIMS = kas_pkg::NUM_ANIMS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_opcode,
   input  wire  [kas_pkg::REQ_W-1:0]    req_anim_request,
   input  wire  [kas_pkg::TIME_W-1:0]   req_now_time,
   input  wire  [kas_pkg::FIELD_W-1:0]  req_first_frame,
   input  wire  [kas_pkg::FIELD_W-1:0]  req_num_frames,
   input  wire  [kas_pkg::FIELD_W-1:0]  req_loop_frames,
   input  wire  [kas_pkg::FIELD_W-1:0]  req_frame_period,
   input  wire  [kas_pkg::FIELD_W-1:0]  req_start_delay,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [kas_pkg::FRAME_W-1:0]  rsp_old_frame,
   output logic [kas_pkg::FRAME_W-1:0]  rsp_cur_frame,
   output logic [kas_pkg::LERP_W-1:0]   rsp_back_lerp,
   output logic                         rsp_bad_index
);
   import kas_pkg::*;

   localparam int ADDR_W = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;

   // sequencer and architectural state
   state_type            state_ff, state_in;
   logic [REQ_W-1:0]     cur_anim_ff, cur_anim_in;
   logic                 anim_valid_ff, anim_valid_in;
   logic [DUE_W-1:0]     frame_due_ff, frame_due_in;
   logic [DUE_W-1:0]     old_frame_due_ff, old_frame_due_in;
   logic [DUE_W-1:0]     anim_start_ff, anim_start_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [FRAME_W-1:0]   old_frame_ff, old_frame_in;

   // per-item working registers
   logic [REQ_W-1:0]     req_ff, req_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic                 bad_ff, bad_in;
   logic [FIELD_W-1:0]   first_ff, first_in;
   logic [FIELD_W-1:0]   nf_ff, nf_in;
   logic [FIELD_W-1:0]   lp_ff, lp_in;
   logic [FIELD_W-1:0]   per_ff, per_in;
   logic [FT_W-1:0]      ft_ff, ft_in;
   logic [DUE_W-1:0]     oft_ff, oft_in;
   logic [DIFF_W-1:0]    diff_ff, diff_in;
   logic                 neg_ff, neg_in;
   logic [LERP_W-1:0]    back_ff, back_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]   rsp_old_frame_ff, rsp_old_frame_in;
   logic [FRAME_W-1:0]   rsp_cur_frame_ff, rsp_cur_frame_in;
   logic [LERP_W-1:0]    rsp_back_lerp_ff, rsp_back_lerp_in;
   logic                 rsp_bad_index_ff, rsp_bad_index_in;

   // submodule connections
   entry_type            wr_entry;
   entry_type            tbl_rd;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // datapath terms
   logic                 req_accept;
   logic                 req_bad;
   logic [DUE_W-1:0]     now_ext;
   logic [DIFF_W-1:0]    diff_mag;
   logic [DIV_W-1:0]     quo;
   logic                 quo_ge_nf;
   logic [FRAME_W-1:0]   frame_pos;
   logic [DIV_W:0]       neg_sum;
   logic [FRAME_W-1:0]   frame_neg;
   logic [FRAME_W-1:0]   hold_sum;
   logic [FRAME_W-1:0]   frame_hold;
   logic [MOD_SUM_W-1:0] mod_sum;
   logic [FRAME_W-1:0]   frame_mod;
   logic [FT_W-1:0]      lead_bound;
   logic [DUE_W-1:0]     lead;
   logic [DIV_W-1:0]     lerp_dividend;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_bad    = {1'b0, req_anim_request[ANIM_IDX_W-1:0]} >= REQ_W'(NUM_ANIMS);

   assign wr_entry = '{start_delay:  req_start_delay,
                       frame_period: req_frame_period,
                       loop_frames:  req_loop_frames,
                       num_frames:   req_num_frames,
                       first_frame:  req_first_frame};

   kas_table #(
      .NUM_ANIMS (NUM_ANIMS),
      .ADDR_W    (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_accept && (req_opcode == OP_LOAD) && !req_bad),
      .wr_addr (req_anim_request[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (req_accept),
      .rd_addr (req_anim_request[ADDR_W-1:0]),
      .rd_data (tbl_rd)
   );

   kas_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign now_ext = DUE_W'(now_ff);

   // frame offset: |ft - anim_start| / period, sign put back afterwards
   assign diff_mag  = diff_ff[DIFF_W-1] ? (DIFF_W'(0) - diff_ff) : diff_ff;
   assign quo       = div_rsp.quotient;
   // a negative offset only counts as past the end when it truncated to zero
   assign quo_ge_nf = (!neg_ff || (quo == '0)) && (quo >= DIV_W'(nf_ff));

   // frame inside the animation, positive or negative offset
   assign frame_pos = FRAME_W'(DIV_W'(first_ff) + quo);
   assign neg_sum   = {1'b0, DIV_W'(first_ff)} - {1'b0, quo};
   assign frame_neg = neg_sum[DIV_W] ? '0 : neg_sum[FRAME_W-1:0];

   // hold on the last frame; zero frames with first frame zero saturates at 0
   assign hold_sum   = FRAME_W'(first_ff) + FRAME_W'(nf_ff);
   assign frame_hold = (hold_sum == '0) ? '0 : (hold_sum - FRAME_W'(1));

   // loop tail: first + (offset mod loop) + frames - loop, floored at 0
   assign mod_sum   = MOD_SUM_W'(first_ff) + MOD_SUM_W'(div_rsp.remainder[FIELD_W-1:0])
                    + MOD_SUM_W'(nf_ff);
   assign frame_mod = (mod_sum >= MOD_SUM_W'(lp_ff)) ?
                      FRAME_W'(mod_sum - MOD_SUM_W'(lp_ff)) : '0;

   assign lead_bound = {1'b0, now_ext + DUE_W'(LEAD_LIMIT)};

   // frame_due - now never exceeds the lead limit here, so the low bits suffice
   assign lead          = frame_due_ff - now_ext;
   assign lerp_dividend = DIV_W'({lead[LEAD_W-1:0], {FRAC_W{1'b0}}});

   always_comb begin
      state_in         = state_ff;
      cur_anim_in      = cur_anim_ff;
      anim_valid_in    = anim_valid_ff;
      frame_due_in     = frame_due_ff;
      old_frame_due_in = old_frame_due_ff;
      anim_start_in    = anim_start_ff;
      frame_in         = frame_ff;
      old_frame_in     = old_frame_ff;
      req_in           = req_ff;
      now_in           = now_ff;
      bad_in           = bad_ff;
      first_in         = first_ff;
      nf_in            = nf_ff;
      lp_in            = lp_ff;
      per_in           = per_ff;
      ft_in            = ft_ff;
      oft_in           = oft_ff;
      diff_in          = diff_ff;
      neg_in           = neg_ff;
      back_in          = back_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_old_frame_in = rsp_old_frame_ff;
      rsp_cur_frame_in = rsp_cur_frame_ff;
      rsp_back_lerp_in = rsp_back_lerp_ff;
      rsp_bad_index_in = rsp_bad_index_ff;
      div_req          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in  = req_anim_request;
               now_in  = req_now_time;
               bad_in  = req_bad;
               back_in = '0;
               case (req_opcode)
                  OP_LOAD: state_in = ST_EMIT;
                  OP_TICK: state_in = req_bad ? ST_EMIT : ST_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // table entry is on tbl_rd; switch animation on a changed request
         ST_READ: begin
            if ((req_ff != cur_anim_ff) || !anim_valid_ff) begin
               cur_anim_in   = req_ff;
               anim_valid_in = 1'b1;
               anim_start_in = frame_due_ff + DUE_W'(tbl_rd.start_delay);
            end
            first_in = tbl_rd.first_frame;
            nf_in    = tbl_rd.num_frames;
            lp_in    = tbl_rd.loop_frames;
            per_in   = (tbl_rd.frame_period == '0) ? FIELD_W'(1) : tbl_rd.frame_period;
            state_in = ST_STEP;
         end

         ST_STEP: begin
            if (now_ext >= frame_due_ff) begin
               old_frame_in = frame_ff;
               oft_in       = frame_due_ff;
               ft_in        = (now_ext < anim_start_ff) ? {1'b0, anim_start_ff} :
                              ({1'b0, frame_due_ff} + FT_W'(per_ff));
               state_in     = ST_DIFF;
            end else begin
               ft_in    = {1'b0, frame_due_ff};
               oft_in   = old_frame_due_ff;
               state_in = ST_CLAMP;
            end
         end

         ST_DIFF: begin
            diff_in  = {1'b0, ft_ff} - DIFF_W'(anim_start_ff);
            state_in = ST_QUO_GO;
         end

         ST_QUO_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = diff_mag[DIV_W-1:0];
            div_req.divisor  = DIV_W'(per_ff);
            neg_in           = diff_ff[DIFF_W-1];
            state_in         = ST_QUO_WAIT;
         end

         ST_QUO_WAIT: begin
            if (div_rsp.done) begin
               if (quo_ge_nf) begin
                  if (lp_ff != '0) begin
                     state_in = ST_MOD_GO;
                  end else begin
                     frame_in = frame_hold;
                     ft_in    = FT_W'(now_ff);
                     state_in = ST_CLAMP;
                  end
               end else begin
                  frame_in = neg_ff ? frame_neg : frame_pos;
                  state_in = ST_CLAMP;
               end
            end
         end

         // quotient stays on the divider outputs until the next start
         ST_MOD_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = quo - DIV_W'(nf_ff);
            div_req.divisor  = DIV_W'(lp_ff);
            state_in         = ST_MOD_WAIT;
         end

         ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               frame_in = frame_mod;
               state_in = ST_CLAMP;
            end
         end

         ST_CLAMP: begin
            if (FT_W'(now_ff) > ft_ff) begin
               ft_in = FT_W'(now_ff);
            end
            state_in = ST_LIMIT;
         end

         ST_LIMIT: begin
            frame_due_in     = (ft_ff > lead_bound) ? now_ext : ft_ff[DUE_W-1:0];
            old_frame_due_in = (oft_ff > now_ext) ? now_ext : oft_ff;
            state_in         = ST_LERP_GO;
         end

         ST_LERP_GO: begin
            if (frame_due_ff == old_frame_due_ff) begin
               back_in  = '0;
               state_in = ST_EMIT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = lerp_dividend;
               div_req.divisor  = frame_due_ff - old_frame_due_ff;
               state_in         = ST_LERP_WAIT;
            end
         end

         ST_LERP_WAIT: begin
            if (div_rsp.done) begin
               back_in  = quo[LERP_W-1:0];
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_old_frame_in = old_frame_ff;
               rsp_cur_frame_in = frame_ff;
               rsp_back_lerp_in = back_ff;
               rsp_bad_index_in = bad_ff;
               state_in         = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cur_anim_ff      <= '0;
         anim_valid_ff    <= 1'b0;
         frame_due_ff     <= '0;
         old_frame_due_ff <= '0;
         anim_start_ff    <= '0;
         frame_ff         <= '0;
         old_frame_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cur_anim_ff      <= cur_anim_in;
         anim_valid_ff    <= anim_valid_in;
         frame_due_ff     <= frame_due_in;
         old_frame_due_ff <= old_frame_due_in;
         anim_start_ff    <= anim_start_in;
         frame_ff         <= frame_in;
         old_frame_ff     <= old_frame_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff           <= req_in;
      now_ff           <= now_in;
      bad_ff           <= bad_in;
      first_ff         <= first_in;
      nf_ff            <= nf_in;
      lp_ff            <= lp_in;
      per_ff           <= per_in;
      ft_ff            <= ft_in;
      oft_ff           <= oft_in;
      diff_ff          <= diff_in;
      neg_ff           <= neg_in;
      back_ff          <= back_in;
      rsp_old_frame_ff <= rsp_old_frame_in;
      rsp_cur_frame_ff <= rsp_cur_frame_in;
      rsp_back_lerp_ff <= rsp_back_lerp_in;
      rsp_bad_index_ff <= rsp_bad_index_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_old_frame = rsp_old_frame_ff;
   assign rsp_cur_frame = rsp_cur_frame_ff;
   assign rsp_back_lerp = rsp_back_lerp_ff;
   assign rsp_bad_index = rsp_bad_index_ff;

   // divider is only started when idle
   `KAS_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy, "divider restarted while busy")
   // stored frame time never leads now by more than the limit
   `KAS_ASSERT_IMPLY(a_lead_limit, clock, reset, state_ff == ST_LERP_GO, frame_due_ff <= (now_ext + DUE_W'(LEAD_LIMIT)), "frame time beyond lead limit")
   // blend interval never runs backwards
   `KAS_ASSERT_IMPLY(a_due_order, clock, reset, state_ff == ST_LERP_GO, (old_frame_due_ff <= now_ext) && (now_ext <= frame_due_ff), "blend interval out of order")
   // a load goes straight to the result
   `KAS_ASSERT_NEXT(a_load_emit, clock, reset, req_accept && (req_opcode == OP_LOAD), state_ff == ST_EMIT, "load did not go to emit")

endmodule

`default_nettype wire

// ===== sim/tb_keyframe_animation_sequencer.sv =====
// Self-checking testbench for keyframe_animation_sequencer: directed table, then random traffic.
// Depends on kas_pkg and the block's RTL; every result is scored against an in-bench model or a typed-in result.
module tb_keyframe_animation_sequencer;
   import kas_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   // Allow for the slowest tick, the longest receiver stall and sender gap, then margin.
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 150;
   localparam int SLOT_W       = $clog2(NUM_ANIMS_DEF);

   // One input transfer, plus an optional hand-typed result for the directed rows.
   typedef struct {
      logic                opcode;
      logic [REQ_W-1:0]    req;
      logic [TIME_W-1:0]   now;
      logic [FIELD_W-1:0]  ff;
      logic [FIELD_W-1:0]  nf;
      logic [FIELD_W-1:0]  lp;
      logic [FIELD_W-1:0]  per;
      logic [FIELD_W-1:0]  sd;
      bit                  typed;
      logic [FRAME_W-1:0]  typed_old;
      logic [FRAME_W-1:0]  typed_cur;
      logic [LERP_W-1:0]   typed_lerp;
      logic                typed_bad;
   } anim_item_type;

   typedef struct {
      logic [FRAME_W-1:0] old_frame;
      logic [FRAME_W-1:0] cur_frame;
      logic [LERP_W-1:0]  back_lerp;
      logic               bad_index;
   } blend_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic                 req_opcode       = OP_LOAD;
   logic [REQ_W-1:0]     req_anim_request = '0;
   logic [TIME_W-1:0]    req_now_time     = '0;
   logic [FIELD_W-1:0]   req_first_frame  = '0;
   logic [FIELD_W-1:0]   req_num_frames   = '0;
   logic [FIELD_W-1:0]   req_loop_frames  = '0;
   logic [FIELD_W-1:0]   req_frame_period = '0;
   logic [FIELD_W-1:0]   req_start_delay  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [FRAME_W-1:0]   rsp_old_frame;
   logic [FRAME_W-1:0]   rsp_cur_frame;
   logic [LERP_W-1:0]    rsp_back_lerp;
   logic                 rsp_bad_index;

   keyframe_animation_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_anim_request (req_anim_request),
      .req_now_time     (req_now_time),
      .req_first_frame  (req_first_frame),
      .req_num_frames   (req_num_frames),
      .req_loop_frames  (req_loop_frames),
      .req_frame_period (req_frame_period),
      .req_start_delay  (req_start_delay),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_old_frame    (rsp_old_frame),
      .rsp_cur_frame    (rsp_cur_frame),
      .rsp_back_lerp    (rsp_back_lerp),
      .rsp_bad_index    (rsp_bad_index)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Shadow of the sequencer. Table entries are left X until loaded, so a stray read of an
   // unloaded entry shows up as X in the expected frames.
   // ---------------------------------------------------------------------------------------
   entry_type          shadow_table [NUM_ANIMS_DEF];
   logic [REQ_W-1:0]   seq_req     = '0;   // request incl. toggle bit
   logic               seq_active  = 1'b0;
   logic [DUE_W-1:0]   due_ms      = '0;   // time of next frame change
   logic [DUE_W-1:0]   old_due_ms  = '0;   // time of the last frame change
   logic [DUE_W-1:0]   start_ms    = '0;   // animation start
   logic [FRAME_W-1:0] frame_now   = '0;
   logic [FRAME_W-1:0] frame_prev  = '0;

   bit [NUM_ANIMS_DEF-1:0] loaded_slots = '0;   // ticks only go to loaded entries

   blend_result_type pending_blends[$];
   int               mismatch_count = 0;
   int               results_seen   = 0;
   int               burst_left     = 0;
   int               idle_cycles    = 0;

   // Frame step and blend weight for one transfer; updates the shadow state.
   function automatic blend_result_type predict_blend(anim_item_type item);
      blend_result_type        r;
      logic [ANIM_IDX_W-1:0]   idx;
      logic                    bad;
      entry_type               e;
      longint                  now_ms, ft, oft, at, per, nf, lp, ff, f, sum, n, d;
      idx         = item.req[ANIM_IDX_W-1:0];
      bad         = (idx >= NUM_ANIMS_DEF);
      r.back_lerp = '0;
      r.bad_index = bad;
      if (item.opcode == OP_LOAD && !bad) begin
         shadow_table[idx[SLOT_W-1:0]] = '{start_delay: item.sd, frame_period: item.per,
                                           loop_frames: item.lp, num_frames: item.nf,
                                           first_frame: item.ff};
      end
      if (item.opcode == OP_TICK && !bad) begin
         now_ms = longint'(item.now);
         // new request (toggle counts): restart one start delay after the pending change
         if (item.req != seq_req || !seq_active) begin
            seq_req    = item.req;
            seq_active = 1'b1;
            start_ms   = due_ms + DUE_W'(shadow_table[idx[SLOT_W-1:0]].start_delay);
         end
         e   = shadow_table[idx[SLOT_W-1:0]];
         per = longint'(e.frame_period);
         if (per == 0) begin
            per = 1;
         end
         nf  = longint'(e.num_frames);
         lp  = longint'(e.loop_frames);
         ff  = longint'(e.first_frame);
         ft  = longint'(due_ms);
         oft = longint'(old_due_ms);
         at  = longint'(start_ms);
         if (now_ms >= ft) begin
            frame_prev = frame_now;
            oft        = ft;
            if (now_ms < at) begin
               ft = at;
            end else begin
               ft = oft + per;
            end
            f = (ft - at) / per;   // truncates toward zero, may be negative
            if (f >= nf) begin
               f -= nf;
               if (lp != 0) begin
                  f = f % lp;
                  f += nf - lp;
               end else begin
                  f  = nf - 1;     // hold the last frame
                  ft = now_ms;
               end
            end
            sum = ff + f;
            if (sum < 0) begin
               sum = 0;
            end
            frame_now = sum[FRAME_W-1:0];
            if (now_ms > ft) begin
               ft = now_ms;
            end
         end
         if (ft > now_ms + LEAD_LIMIT) begin
            ft = now_ms;
         end
         if (oft > now_ms) begin
            oft = now_ms;
         end
         due_ms     = ft[DUE_W-1:0];
         old_due_ms = oft[DUE_W-1:0];
         d = ft - oft;
         n = now_ms - oft;
         if (d > 0 && n >= 0 && n <= d) begin
            r.back_lerp = LERP_W'(((d - n) * ONE_Q16) / d);
         end
      end
      r.old_frame = frame_prev;
      r.cur_frame = frame_now;
      return r;
   endfunction

   function automatic anim_item_type make_item(logic op, logic [REQ_W-1:0] req,
                                               logic [TIME_W-1:0] now,
                                               logic [FIELD_W-1:0] ff, logic [FIELD_W-1:0] nf,
                                               logic [FIELD_W-1:0] lp, logic [FIELD_W-1:0] per,
                                               logic [FIELD_W-1:0] sd);
      anim_item_type item;
      item.opcode = op;
      item.req    = req;
      item.now    = now;
      item.ff     = ff;
      item.nf     = nf;
      item.lp     = lp;
      item.per    = per;
      item.sd     = sd;
      item.typed  = 1'b0;
      item.typed_old  = '0;
      item.typed_cur  = '0;
      item.typed_lerp = '0;
      item.typed_bad  = 1'b0;
      return item;
   endfunction

   function automatic anim_item_type with_result(anim_item_type item, logic [FRAME_W-1:0] o,
                                                 logic [FRAME_W-1:0] c, logic [LERP_W-1:0] b,
                                                 logic bad);
      item.typed      = 1'b1;
      item.typed_old  = o;
      item.typed_cur  = c;
      item.typed_lerp = b;
      item.typed_bad  = bad;
      return item;
   endfunction

   // Present one item and hold it until the transfer; the shadow is advanced at that edge.
   task automatic send_item(anim_item_type item);
      blend_result_type want;
      req_valid        <= 1'b1;
      req_opcode       <= item.opcode;
      req_anim_request <= item.req;
      req_now_time     <= item.now;
      req_first_frame  <= item.ff;
      req_num_frames   <= item.nf;
      req_loop_frames  <= item.lp;
      req_frame_period <= item.per;
      req_start_delay  <= item.sd;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = predict_blend(item);
      if (item.typed) begin
         want = '{item.typed_old, item.typed_cur, item.typed_lerp, item.typed_bad};
      end
      pending_blends.push_back(want);
      if (item.opcode == OP_LOAD && item.req[ANIM_IDX_W-1:0] < NUM_ANIMS_DEF) begin
         loaded_slots[item.req[SLOT_W-1:0]] = 1'b1;
      end
   endtask

   // Sender pacing: bursts of random length, mostly separated by random gaps.
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Hold off the sender until every pending result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, blend_result_type want, blend_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("result %0d %s: want old=%0d cur=%0d lerp=%0d bad=%0d, ",
                results_seen, what, want.old_frame, want.cur_frame, want.back_lerp,
                want.bad_index);
         $display("got old=%0d cur=%0d lerp=%0d bad=%0d",
                  got.old_frame, got.cur_frame, got.back_lerp, got.bad_index);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: stall pattern of its own, switching between no stall, coin flips, heavy
   // stall and long fixed runs.
   // ---------------------------------------------------------------------------------------
   int stall_mode = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 1) == 1);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 7) != 0);
         end
         default: begin
            rsp_stall <= stall_left[4];
         end
      endcase
   end

   // Score every result transfer against the oldest pending prediction, field by field.
   always @(posedge clock) begin : score_results
      blend_result_type want;
      blend_result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{rsp_old_frame, rsp_cur_frame, rsp_back_lerp, rsp_bad_index};
         if (pending_blends.size() == 0) begin
            want = '{'0, '0, '0, 1'b0};
            report_mismatch("with nothing pending", want, got);
         end else begin
            want = pending_blends.pop_front();
            if (got.old_frame !== want.old_frame || got.cur_frame !== want.cur_frame ||
                got.back_lerp !== want.back_lerp || got.bad_index !== want.bad_index) begin
               report_mismatch("differs", want, got);
            end
         end
         results_seen++;
      end
   end

   // Watchdog: too long without a transfer on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      anim_item_type         dir_rows[$];
      anim_item_type         item;
      int                    roll;
      int                    k;
      logic [ANIM_IDX_W-1:0] slot;
      logic [TIME_W-1:0]     sim_ms;
      logic [REQ_W-1:0]      live_req;
      logic [FIELD_W-1:0]    nf;

      // Directed rows. Loads before the first tick leave both frames at zero, and any bad
      // index only sets the flag, so those results are typed in.
      dir_rows.push_back(with_result(make_item(OP_LOAD, 8'h00, '0, 10'd0, 10'd4, 10'd2,
                                               10'd10, 10'd20), '0, '0, '0, 1'b0));
      // bad index load with every field at its top value: nothing written
      dir_rows.push_back(with_result(make_item(OP_LOAD, 8'hFF, '1, '1, '1, '1, '1, '1),
                                     '0, '0, '0, 1'b1));
      // bad index ticks, first index past the table and with toggle set
      dir_rows.push_back(with_result(make_item(OP_TICK, 8'h20, '0, '0, '0, '0, '0, '0),
                                     '0, '0, '0, 1'b1));
      dir_rows.push_back(with_result(make_item(OP_TICK, 8'hA0, '1, '1, '1, '1, '1, '1),
                                     '0, '0, '0, 1'b1));
      dir_rows.push_back(with_result(make_item(OP_LOAD, 8'h1F, '0, '1, '1, '1, '1, '1),
                                     '0, '0, '0, 1'b0));
      // zero frames, zero period (used as one), zero delay
      dir_rows.push_back(with_result(make_item(OP_LOAD, 8'h01, '0, 10'd5, 10'd0, 10'd0,
                                               10'd0, 10'd0), '0, '0, '0, 1'b0));
      // loop tail longer than the animation
      dir_rows.push_back(with_result(make_item(OP_LOAD, 8'h02, '0, 10'd100, 10'd3, 10'd7,
                                               10'd1, 10'd1), '0, '0, '0, 1'b0));
      // hold last frame, long period and delay
      dir_rows.push_back(with_result(make_item(OP_LOAD, 8'h03, '0, 10'd1023, 10'd1023, 10'd0,
                                               10'd1000, 10'd1000), '0, '0, '0, 1'b0));
      // ticks: start, mid-frame blend, steps, loop wrap
      dir_rows.push_back(make_item(OP_TICK, 8'h00, 31'd0, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h00, 31'd5, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h00, 31'd30, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h00, 31'd100, '0, '0, '0, '0, '0));
      // toggle restarts the same animation
      dir_rows.push_back(make_item(OP_TICK, 8'h80, 31'd120, '0, '0, '0, '0, '0));
      // time runs backward: old change time clamped to now
      dir_rows.push_back(make_item(OP_TICK, 8'h80, 31'd50, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h80, 31'd1000, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h01, 31'd1010, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h01, 31'd1020, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h02, 31'd1030, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h02, 31'd1100, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h03, 31'd2000, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h03, '1, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_TICK, 8'h1F, '1, '0, '0, '0, '0, '0));
      // next change far past now: lead clamp
      dir_rows.push_back(make_item(OP_TICK, 8'h1F, 31'd0, '0, '0, '0, '0, '0));
      dir_rows.push_back(make_item(OP_LOAD, 8'h9F, '0, 10'd512, 10'd8, 10'd3, 10'd4, 10'd2));
      dir_rows.push_back(make_item(OP_TICK, 8'h9F, 31'd10, '0, '0, '0, '0, '0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_item(dir_rows[i]);
         pace();
      end
      // hold the sender back until the directed results are all in
      drain_results();

      sim_ms   = 31'd3000;
      live_req = 8'h00;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         roll = $urandom_range(0, 99);
         item = make_item(OP_TICK, live_req, sim_ms, 10'($urandom), 10'($urandom),
                          10'($urandom), 10'($urandom), 10'($urandom));
         if (roll < 8) begin
            // table load, mostly short animations with short periods so frames move
            slot         = ANIM_IDX_W'($urandom_range(0, NUM_ANIMS_DEF - 1));
            item.opcode  = OP_LOAD;
            item.req     = {1'($urandom_range(0, 1)), slot};
            nf           = ($urandom_range(0, 9) == 0) ? 10'($urandom) :
                           10'($urandom_range(1, 24));
            item.nf      = nf;
            roll         = $urandom_range(0, 9);
            item.lp      = (roll < 3) ? 10'd0 :
                           (roll < 9) ? 10'($urandom_range(1, (nf == 0) ? 1 : nf)) :
                           10'($urandom);
            roll         = $urandom_range(0, 9);
            item.per     = (roll < 8) ? 10'($urandom_range(1, 40)) :
                           (roll == 8) ? 10'd0 : 10'($urandom);
            item.sd      = ($urandom_range(0, 4) != 0) ? 10'($urandom_range(1, 60)) :
                           10'($urandom);
         end else if (roll < 10) begin
            item.opcode = OP_LOAD;
            item.req    = {1'($urandom_range(0, 1)), 7'($urandom_range(NUM_ANIMS_DEF, 127))};
         end else if (roll < 14) begin
            item.req = {1'($urandom_range(0, 1)), 7'($urandom_range(NUM_ANIMS_DEF, 127))};
            item.now = TIME_W'($urandom);
         end else begin
            // tick on a loaded entry: mostly the running animation, sometimes a switch
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               do slot = ANIM_IDX_W'($urandom_range(0, NUM_ANIMS_DEF - 1));
               while (!loaded_slots[slot[SLOT_W-1:0]]);
               live_req = {1'($urandom_range(0, 1)), slot};
            end else if (roll < 15) begin
               live_req[REQ_W-1] = ~live_req[REQ_W-1];
            end
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
               sim_ms = sim_ms + TIME_W'($urandom_range(0, 40));
            end else if (roll < 92) begin
               sim_ms = sim_ms - TIME_W'($urandom_range(0, 300));
            end else if (roll < 97) begin
               sim_ms = sim_ms + TIME_W'($urandom_range(100, 3000));
            end else begin
               sim_ms = TIME_W'($urandom);
            end
            item.req = live_req;
            item.now = sim_ms;
         end
         send_item(item);
         if (k % 250 == 249) begin
            drain_results();
         end else begin
            pace();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_blends.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/kas_pkg.sv
design/kas_div.sv
design/kas_table.sv
design/keyframe_animation_sequencer.sv
sim/tb_keyframe_animation_sequencer.sv
